// ----- src/plst_pkg.sv -----
// plst_pkg: shared codes, field widths, bus layout and the memory control
// struct of the positional list store. No dependencies.
`default_nettype none

package plst_pkg;

   // operation codes (req_tuser)
   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_REMOVE  = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;
   localparam logic [1:0] OP_REPLACE = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BADPOS = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   // field widths
   localparam int OPCODE_W = 2;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int LEN_W    = 5;
   localparam int STATUS_W = 2;

   // bus layout
   localparam int REQ_TDATA_W = ((POS_W + VALUE_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((VALUE_W + LEN_W + STATUS_W + 7) / 8) * 8;
   localparam int REQ_PAD_W   = REQ_TDATA_W - POS_W - VALUE_W;
   localparam int RSP_PAD_W   = RSP_TDATA_W - VALUE_W - LEN_W - STATUS_W;

   // parameter defaults
   localparam int DEF_CAPACITY   = 16;
   localparam int DEF_DATA_WIDTH = 32;

   // sequencer to entry memory
   typedef struct packed {
      logic rd_en;         // latch the addressed entry
      logic wr_en;         // write the addressed entry
      logic wr_sel_input;  // write data: 1 = request value, 0 = latched entry
   } mem_ctl_type;

endpackage

`default_nettype wire

// ----- src/positional_list_store.sv -----
// positional_list_store: top level of the bounded positional list.
// Depends on plst_pkg, plst_store and plst_seq.
`default_nettype none

//  channel   dir   transaction carries
//  --------  ----  ---------------------------------------------------------
//  req_*     in    tuser: opcode; tdata: position, value
//  rsp_*     out   tdata: read_value, list_length, status
//
//  One transaction at a time; the list is a single-port memory and a shift
//  moves one entry at a time (read, then write back one place over).
//  Reset clears the length; entries hold no reset value and are only read
//  after they were written. A result waits in the rsp_ register while the
//  next request is accepted; only its completion stalls on rsp_tready.

module positional_list_store #(
   parameter int CAPACITY   = plst_pkg::DEF_CAPACITY,
   parameter int DATA_WIDTH = plst_pkg::DEF_DATA_WIDTH
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // request stream
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [plst_pkg::REQ_TDATA_W-1:0]     req_tdata,   // position, value, zero pad
   input  wire  [plst_pkg::OPCODE_W-1:0]        req_tuser,   // opcode
   // result stream
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [plst_pkg::RSP_TDATA_W-1:0]     rsp_tdata    // read_value, list_length,
                                                             // status, zero pad
);

   localparam int AW = $clog2(CAPACITY);

   plst_pkg::mem_ctl_type              mem_ctl;
   logic [AW-1:0]                      mem_addr;
   logic [DATA_WIDTH-1:0]              mem_wr_value;
   logic [DATA_WIDTH-1:0]              mem_rd_q;

   logic                               res_valid;
   logic                               res_ready;
   logic [plst_pkg::VALUE_W-1:0]       res_read_value;
   logic [plst_pkg::LEN_W-1:0]         res_list_length;
   logic [plst_pkg::STATUS_W-1:0]      res_status;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [plst_pkg::VALUE_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [plst_pkg::LEN_W-1:0]         rsp_len_ff, rsp_len_in;
   logic [plst_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;

   // unpack request fields, position in the low bits
   logic [plst_pkg::POS_W-1:0]         req_position;
   logic [plst_pkg::VALUE_W-1:0]       req_value;

   assign req_position = req_tdata[plst_pkg::POS_W-1:0];
   assign req_value    = req_tdata[plst_pkg::POS_W +: plst_pkg::VALUE_W];

   plst_seq #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_opcode      (req_tuser),
      .req_position    (req_position),
      .req_value       (req_value),
      .mem_ctl         (mem_ctl),
      .mem_addr        (mem_addr),
      .mem_wr_value    (mem_wr_value),
      .mem_rd_q        (mem_rd_q),
      .res_valid       (res_valid),
      .res_ready       (res_ready),
      .res_read_value  (res_read_value),
      .res_list_length (res_list_length),
      .res_status      (res_status)
   );

   plst_store #(
      .DEPTH (CAPACITY),
      .AW    (AW),
      .DW    (DATA_WIDTH)
   ) u_store (
      .clock    (clock),
      .ctl      (mem_ctl),
      .addr     (mem_addr),
      .wr_value (mem_wr_value),
      .rd_q     (mem_rd_q)
   );

   // the register takes a new result when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_status_in = rsp_status_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
      end
      if (res_valid && res_ready) begin
         rsp_value_in  = res_read_value;
         rsp_len_in    = res_list_length;
         rsp_status_in = res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{plst_pkg::RSP_PAD_W{1'b0}}, rsp_status_ff, rsp_len_ff, rsp_value_ff};

endmodule

`default_nettype wire

// ----- src/plst_store.sv -----
// plst_store: single-port entry memory with registered read data.
// Depends on plst_pkg (mem_ctl_type).
`default_nettype none

module plst_store #(
   parameter int DEPTH = plst_pkg::DEF_CAPACITY,
   parameter int AW    = $clog2(plst_pkg::DEF_CAPACITY),
   parameter int DW    = plst_pkg::DEF_DATA_WIDTH
) (
   input  wire                      clock,
   input  plst_pkg::mem_ctl_type    ctl,
   input  wire  [AW-1:0]            addr,
   input  wire  [DW-1:0]            wr_value,
   output logic [DW-1:0]            rd_q
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_q_ff;
   logic [DW-1:0] wdata;

   // a shift step writes back the entry latched in the previous cycle
   assign wdata = ctl.wr_sel_input ? wr_value : rd_q_ff;
   assign rd_q  = rd_q_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wdata;
      end
      if (ctl.rd_en) begin
         rd_q_ff <= mem[addr];
      end
   end

endmodule

`default_nettype wire

// ----- src/plst_seq.sv -----
// plst_seq: operation sequencer with the length count, the shared index
// stepper and the result registers. Depends on plst_pkg.
`default_nettype none

module plst_seq #(
   parameter int CAPACITY   = plst_pkg::DEF_CAPACITY,
   parameter int DATA_WIDTH = plst_pkg::DEF_DATA_WIDTH,
   parameter int AW         = $clog2(plst_pkg::DEF_CAPACITY)
) (
   input  wire                                clock,
   input  wire                                reset,
   // request
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [plst_pkg::OPCODE_W-1:0]      req_opcode,
   input  wire  [plst_pkg::POS_W-1:0]         req_position,
   input  wire  [plst_pkg::VALUE_W-1:0]       req_value,
   // entry memory
   output plst_pkg::mem_ctl_type              mem_ctl,
   output logic [AW-1:0]                      mem_addr,
   output logic [DATA_WIDTH-1:0]              mem_wr_value,
   input  wire  [DATA_WIDTH-1:0]              mem_rd_q,
   // result
   output logic                               res_valid,
   input  wire                                res_ready,
   output logic [plst_pkg::VALUE_W-1:0]       res_read_value,
   output logic [plst_pkg::LEN_W-1:0]         res_list_length,
   output logic [plst_pkg::STATUS_W-1:0]      res_status
);

   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CW > plst_pkg::POS_W) ? CW : plst_pkg::POS_W) + 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_WR   = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]                        state_ff, state_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [plst_pkg::OPCODE_W-1:0]     op_ff, op_in;
   logic [AW-1:0]                     idx_ff, idx_in;
   logic [AW-1:0]                     end_ff, end_in;
   logic [DATA_WIDTH-1:0]             value_ff, value_in;
   logic [plst_pkg::VALUE_W-1:0]      rd_ff, rd_in;
   logic [plst_pkg::STATUS_W-1:0]     status_ff, status_in;

   logic                              accept;
   logic                              is_ins;
   logic                              bad_pos;
   logic                              full;
   logic [CMP_W-1:0]                  pos_x;
   logic [CMP_W-1:0]                  n_x;
   logic [plst_pkg::POS_W-1:0]        pos_m1;
   logic [AW-1:0]                     p0;
   logic [AW-1:0]                     n_idx;
   logic [AW-1:0]                     n_m1;
   logic [AW-1:0]                     idx_step;

   // request checks against the current length
   assign accept  = (state_ff == S_IDLE) && req_valid;
   assign is_ins  = (req_opcode == plst_pkg::OP_INSERT);
   assign pos_x   = CMP_W'(req_position);
   assign n_x     = CMP_W'(count_ff);
   assign bad_pos = (req_position == '0) ||
                    (is_ins ? (pos_x > (n_x + CMP_W'(1))) : (pos_x > n_x));
   assign full    = is_ins && (count_ff == CW'(CAPACITY));
   assign pos_m1  = req_position - plst_pkg::POS_W'(1);
   assign p0      = AW'(pos_m1);
   assign n_idx   = AW'(count_ff);
   assign n_m1    = AW'(count_ff - CW'(1));

   // shared index stepper: insert walks down, remove walks up
   assign idx_step = (op_ff == plst_pkg::OP_INSERT) ? (idx_ff - AW'(1)) : (idx_ff + AW'(1));

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      op_in     = op_ff;
      idx_in    = idx_ff;
      end_in    = end_ff;
      value_in  = value_ff;
      rd_in     = rd_ff;
      status_in = status_ff;
      mem_ctl   = '0;
      mem_addr  = idx_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               op_in    = req_opcode;
               value_in = DATA_WIDTH'(req_value);
               rd_in    = '0;
               if (bad_pos) begin
                  status_in = plst_pkg::ST_BADPOS;
                  state_in  = S_DONE;
               end else if (full) begin
                  status_in = plst_pkg::ST_FULL;
                  state_in  = S_DONE;
               end else begin
                  status_in = plst_pkg::ST_OK;
                  unique case (req_opcode)
                     plst_pkg::OP_INSERT: begin
                        idx_in   = n_idx;
                        end_in   = p0;
                        count_in = count_ff + CW'(1);
                        state_in = (n_idx == p0) ? S_FIN : S_RD;
                     end
                     plst_pkg::OP_REMOVE: begin
                        idx_in   = p0;
                        end_in   = n_m1;
                        count_in = count_ff - CW'(1);
                        state_in = (p0 == n_m1) ? S_DONE : S_RD;
                     end
                     plst_pkg::OP_READ: begin
                        idx_in   = p0;
                        state_in = S_RD;
                     end
                     plst_pkg::OP_REPLACE: begin
                        idx_in   = p0;
                        state_in = S_FIN;
                     end
                     default: begin
                        state_in = S_DONE;
                     end
                  endcase
               end
            end
         end
         S_RD: begin
            mem_ctl.rd_en = 1'b1;
            mem_addr      = (op_ff == plst_pkg::OP_READ) ? idx_ff : idx_step;
            state_in      = S_WR;
         end
         S_WR: begin
            if (op_ff == plst_pkg::OP_READ) begin
               rd_in    = plst_pkg::VALUE_W'(mem_rd_q);
               state_in = S_DONE;
            end else begin
               mem_ctl.wr_en = 1'b1;
               idx_in        = idx_step;
               if (idx_step == end_ff) begin
                  state_in = (op_ff == plst_pkg::OP_INSERT) ? S_FIN : S_DONE;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_FIN: begin
            mem_ctl.wr_en        = 1'b1;
            mem_ctl.wr_sel_input = 1'b1;
            state_in             = S_DONE;
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      idx_ff    <= idx_in;
      end_ff    <= end_in;
      value_ff  <= value_in;
      rd_ff     <= rd_in;
      status_ff <= status_in;
   end

   assign mem_wr_value    = value_ff;
   assign res_read_value  = rd_ff;
   assign res_list_length = plst_pkg::LEN_W'(count_ff);
   assign res_status      = status_ff;

   // length never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("list length above capacity");

   // a rejected transaction leaves the length as it was
   a_reject_keeps_len: assert property (@(posedge clock) disable iff (reset)
      (accept && (bad_pos || full)) |=> (count_ff == $past(count_ff)))
      else $error("rejected transaction changed the length");

   // every memory write lands inside the capacity
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |-> ({1'b0, mem_addr} < (AW + 1)'(CAPACITY)))
      else $error("entry write outside capacity");

   // handing off a result returns the sequencer to idle
   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ready) |=> (state_ff == S_IDLE))
      else $error("sequencer did not return to idle");

   // a result status is always a defined code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (res_status == plst_pkg::ST_OK || res_status == plst_pkg::ST_BADPOS ||
                     res_status == plst_pkg::ST_FULL))
      else $error("undefined status code");

endmodule

`default_nettype wire
